### sv/flff_pkg.sv
// ----------------------------------------------------------------------------
// flff_pkg
// shared types and constants for the first-fit free-list allocator
// ----------------------------------------------------------------------------
package flff_pkg;

    localparam int HEAP_UNITS = 65536;
    localparam int UNIT_BYTES = 16;
    localparam int UNIT_SHIFT = $clog2(UNIT_BYTES);
    localparam int IDX_W      = 16;
    localparam int TOP_W      = IDX_W + 1;
    localparam int WALK_LIMIT = 4 * HEAP_UNITS + 8;
    localparam int STEP_W     = $clog2(WALK_LIMIT + 2);
    localparam int MIN_GROW_RESET = 1024;

    localparam logic [1:0] ST_GRANTED = 2'd0;
    localparam logic [1:0] ST_ZERO    = 2'd1;
    localparam logic [1:0] ST_NOMEM   = 2'd2;
    localparam logic [1:0] ST_FREED   = 2'd3;

    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_FREE  = 1'b1;

    localparam logic REG_MIN_GROW = 1'b0;

    typedef struct packed {
        logic [IDX_W-1:0] next;
        logic [IDX_W-1:0] size;
    } hdr_t;

endpackage

### sv/free_list_first_fit_allocator.sv
// ----------------------------------------------------------------------------
// free_list_first_fit_allocator
// first-fit heap allocator over an address-ordered circular free list kept
// in a header memory; free inserts by address and merges both neighbors
// ----------------------------------------------------------------------------
//  channel  | signals                                   | dir
//  ---------+-------------------------------------------+-----
//  in       | in_valid in_stall func request_bytes       | in
//           | payload_index                              |
//  out      | out_valid out_stall granted_index status   | out
//  cfg      | psel penable pwrite paddr pwdata prdata     | in/out
//           | pready                                      |
//
//  zero request or ignored free: straight from S_IDLE to S_RESP
//  allocate: S_A_PREV, then S_A_CHECK for each free header visited, S_A_CARVE when a
//  block is split; each heap growth runs the free steps below and restarts at S_A_PREV
//  free: S_I_LOOP for each header visited, then S_I_BP, S_I_Q, S_I_WRP, S_RESP
//  the single read port of the header memory sets the pace of every walk
//  reset clears control state; header memory is not cleared
//  a new item is taken once the result is in the output register
module free_list_first_fit_allocator (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_stall,
    input  logic                        func,
    input  logic [20:0]                 request_bytes,
    input  logic [15:0]                 payload_index,
    output logic                        out_valid,
    input  logic                        out_stall,
    output logic [15:0]                 granted_index,
    output logic [1:0]                  status,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [2:0]                  paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready
);
    import flff_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_A_PREV, S_A_CHECK, S_A_CARVE,
        S_I_LOOP, S_I_BP, S_I_Q, S_I_WRP, S_RESP
    } state_t;

    state_t state_reg, state_next;

    hdr_t mem [HEAP_UNITS];
    hdr_t mem_q_reg;
    hdr_t fwd_data_reg;
    logic fwd_hit_reg;
    hdr_t rd;

    logic             we;
    logic [IDX_W-1:0] waddr, raddr;
    hdr_t             wdata;

    logic [IDX_W-1:0]  rover_reg, rover_next;
    logic [TOP_W-1:0]  heap_top_reg, heap_top_next;
    logic              started_reg, started_next;
    logic [IDX_W-1:0]  min_grow_reg;

    logic [IDX_W-1:0]  prev_reg, prev_next, p_reg, p_next, q_reg, q_next;
    logic [IDX_W-1:0]  bp_reg, bp_next, carve_reg, carve_next;
    hdr_t              prev_hdr_reg, prev_hdr_next, p_hdr_reg, p_hdr_next;
    hdr_t              bp_hdr_reg, bp_hdr_next, nbp_reg, nbp_next;
    logic [TOP_W-1:0]  nunits_reg, nunits_next;
    logic [STEP_W-1:0] steps_reg, steps_next, isteps_reg, isteps_next;
    logic              ret_alloc_reg, ret_alloc_next;
    logic [1:0]        res_status_reg, res_status_next;
    logic [IDX_W-1:0]  res_grant_reg, res_grant_next;

    logic              out_valid_reg, out_valid_next;
    logic [IDX_W-1:0]  out_grant_reg, out_grant_next;
    logic [1:0]        out_status_reg, out_status_next;

    logic [21:0]       rounded;
    logic [TOP_W:0]    units_full;
    logic [TOP_W-1:0]  req_units, grow_units, p_sz;
    logic [TOP_W:0]    grow_end;
    logic              brk;
    hdr_t              nbp;
    logic [IDX_W-1:0]  rem_sz;

    assign rd = fwd_hit_reg ? fwd_data_reg : mem_q_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        mem_q_reg    <= mem[raddr];
        fwd_hit_reg  <= we && (waddr == raddr);
        fwd_data_reg <= wdata;
    end

    // request rounded up to units plus one header unit
    assign rounded    = {1'b0, request_bytes} + 22'(UNIT_BYTES - 1);
    assign units_full = (TOP_W + 1)'(rounded >> UNIT_SHIFT) + (TOP_W + 1)'(1);
    // requests far past the heap saturate, they can never fit anyway
    assign req_units  = units_full[TOP_W] ? '1 : units_full[TOP_W-1:0];
    assign p_sz       = {1'b0, rd.size};
    assign grow_units = (nunits_reg < {1'b0, min_grow_reg}) ? {1'b0, min_grow_reg}
                                                             : nunits_reg;
    assign grow_end   = {1'b0, heap_top_reg} + {1'b0, grow_units};
    assign rem_sz     = rd.size - nunits_reg[IDX_W-1:0];
    assign brk = ((bp_reg > p_reg) && (bp_reg < rd.next)) ||
                 ((p_reg >= rd.next) && ((bp_reg > p_reg) || (bp_reg < rd.next)));

    always_comb
    begin
        if (({1'b0, bp_reg} + {1'b0, bp_hdr_reg.size}) == {1'b0, q_reg})
        begin
            nbp.size = bp_hdr_reg.size + rd.size;
            nbp.next = rd.next;
        end
        else
        begin
            nbp.size = bp_hdr_reg.size;
            nbp.next = q_reg;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        rover_next      = rover_reg;
        heap_top_next   = heap_top_reg;
        started_next    = started_reg;
        prev_next       = prev_reg;
        p_next          = p_reg;
        q_next          = q_reg;
        bp_next         = bp_reg;
        carve_next      = carve_reg;
        prev_hdr_next   = prev_hdr_reg;
        p_hdr_next      = p_hdr_reg;
        bp_hdr_next     = bp_hdr_reg;
        nbp_next        = nbp_reg;
        nunits_next     = nunits_reg;
        steps_next      = steps_reg;
        isteps_next     = isteps_reg;
        ret_alloc_next  = ret_alloc_reg;
        res_status_next = res_status_reg;
        res_grant_next  = res_grant_reg;
        out_valid_next  = out_valid_reg && out_stall;
        out_grant_next  = out_grant_reg;
        out_status_next = out_status_reg;
        we              = 1'b0;
        waddr           = p_reg;
        wdata           = rd;
        raddr           = p_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                raddr = rover_reg;
                if (in_valid)
                begin
                    res_grant_next = '0;
                    if (func == FUNC_FREE)
                    begin
                        res_status_next = ST_FREED;
                        if (started_reg && (payload_index != '0) &&
                            ({1'b0, payload_index - IDX_W'(1)} < heap_top_reg))
                        begin
                            bp_next        = payload_index - IDX_W'(1);
                            p_next         = rover_reg;
                            isteps_next    = '0;
                            ret_alloc_next = 1'b0;
                            state_next     = S_I_LOOP;
                        end
                        else
                        begin
                            state_next = S_RESP;
                        end
                    end
                    else if (request_bytes == '0)
                    begin
                        res_status_next = ST_ZERO;
                        state_next      = S_RESP;
                    end
                    else
                    begin
                        res_status_next = ST_NOMEM;
                        nunits_next     = req_units;
                        steps_next      = '0;
                        prev_next       = rover_reg;
                        if (!started_reg)
                        begin
                            // sentinel becomes a one-entry list
                            we           = 1'b1;
                            waddr        = '0;
                            wdata        = '0;
                            raddr        = '0;
                            rover_next   = '0;
                            prev_next    = '0;
                            started_next = 1'b1;
                        end
                        state_next = S_A_PREV;
                    end
                end
            end

            S_A_PREV:
            begin
                prev_hdr_next = rd;
                p_next        = rd.next;
                raddr         = rd.next;
                state_next    = S_A_CHECK;
            end

            S_A_CHECK:
            begin
                if (steps_reg > STEP_W'(WALK_LIMIT))
                begin
                    state_next = S_RESP;
                end
                else
                begin
                    steps_next = steps_reg + STEP_W'(1);
                    if (p_sz >= nunits_reg)
                    begin
                        rover_next      = prev_reg;
                        res_status_next = ST_GRANTED;
                        if (p_sz == nunits_reg)
                        begin
                            we             = 1'b1;
                            waddr          = prev_reg;
                            wdata.next     = rd.next;
                            wdata.size     = prev_hdr_reg.size;
                            res_grant_next = p_reg + IDX_W'(1);
                            state_next     = S_RESP;
                        end
                        else
                        begin
                            // shrink the block and hand out its tail
                            we             = 1'b1;
                            waddr          = p_reg;
                            wdata.next     = rd.next;
                            wdata.size     = rem_sz;
                            carve_next     = p_reg + rem_sz;
                            res_grant_next = p_reg + rem_sz + IDX_W'(1);
                            state_next     = S_A_CARVE;
                        end
                    end
                    else if (p_reg == rover_reg)
                    begin
                        if (grow_end > (TOP_W + 1)'(HEAP_UNITS))
                        begin
                            state_next = S_RESP;
                        end
                        else
                        begin
                            we             = 1'b1;
                            waddr          = heap_top_reg[IDX_W-1:0];
                            wdata.next     = '0;
                            wdata.size     = grow_units[IDX_W-1:0];
                            heap_top_next  = grow_end[TOP_W-1:0];
                            bp_next        = heap_top_reg[IDX_W-1:0];
                            p_next         = rover_reg;
                            raddr          = rover_reg;
                            isteps_next    = '0;
                            ret_alloc_next = 1'b1;
                            state_next     = S_I_LOOP;
                        end
                    end
                    else
                    begin
                        prev_next     = p_reg;
                        prev_hdr_next = rd;
                        p_next        = rd.next;
                        raddr         = rd.next;
                    end
                end
            end

            S_A_CARVE:
            begin
                we         = 1'b1;
                waddr      = carve_reg;
                wdata.next = '0;
                wdata.size = nunits_reg[IDX_W-1:0];
                state_next = S_RESP;
            end

            S_I_LOOP:
            begin
                p_hdr_next = rd;
                q_next     = rd.next;
                if (brk)
                begin
                    raddr      = bp_reg;
                    state_next = S_I_BP;
                end
                else if ((isteps_reg + STEP_W'(1)) > STEP_W'(WALK_LIMIT))
                begin
                    // walk gave up: list left as it was
                    if (ret_alloc_reg)
                    begin
                        prev_next  = rover_reg;
                        raddr      = rover_reg;
                        state_next = S_A_PREV;
                    end
                    else
                    begin
                        state_next = S_RESP;
                    end
                end
                else
                begin
                    isteps_next = isteps_reg + STEP_W'(1);
                    p_next      = rd.next;
                    raddr       = rd.next;
                end
            end

            S_I_BP:
            begin
                bp_hdr_next = rd;
                raddr       = q_reg;
                state_next  = S_I_Q;
            end

            S_I_Q:
            begin
                we         = 1'b1;
                waddr      = bp_reg;
                wdata      = nbp;
                nbp_next   = nbp;
                state_next = S_I_WRP;
            end

            S_I_WRP:
            begin
                we    = 1'b1;
                waddr = p_reg;
                if (({1'b0, p_reg} + {1'b0, p_hdr_reg.size}) == {1'b0, bp_reg})
                begin
                    wdata.size = p_hdr_reg.size + nbp_reg.size;
                    wdata.next = nbp_reg.next;
                end
                else
                begin
                    wdata.size = p_hdr_reg.size;
                    wdata.next = bp_reg;
                end
                rover_next = p_reg;
                raddr      = p_reg;
                if (ret_alloc_reg)
                begin
                    prev_next  = p_reg;
                    state_next = S_A_PREV;
                end
                else
                begin
                    state_next = S_RESP;
                end
            end

            S_RESP:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    out_valid_next  = 1'b1;
                    out_grant_next  = res_grant_reg;
                    out_status_next = res_status_reg;
                    state_next      = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rover_reg     <= '0;
            heap_top_reg  <= TOP_W'(1);
            started_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            min_grow_reg  <= IDX_W'(MIN_GROW_RESET);
        end
        else
        begin
            state_reg     <= state_next;
            rover_reg     <= rover_next;
            heap_top_reg  <= heap_top_next;
            started_reg   <= started_next;
            out_valid_reg <= out_valid_next;
            if (psel && penable && pwrite && (paddr[2] == REG_MIN_GROW))
            begin
                min_grow_reg <= pwdata[IDX_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prev_reg       <= prev_next;
        p_reg          <= p_next;
        q_reg          <= q_next;
        bp_reg         <= bp_next;
        carve_reg      <= carve_next;
        prev_hdr_reg   <= prev_hdr_next;
        p_hdr_reg      <= p_hdr_next;
        bp_hdr_reg     <= bp_hdr_next;
        nbp_reg        <= nbp_next;
        nunits_reg     <= nunits_next;
        steps_reg      <= steps_next;
        isteps_reg     <= isteps_next;
        ret_alloc_reg  <= ret_alloc_next;
        res_status_reg <= res_status_next;
        res_grant_reg  <= res_grant_next;
        out_grant_reg  <= out_grant_next;
        out_status_reg <= out_status_next;
    end

    assign in_stall      = (state_reg != S_IDLE);
    assign out_valid     = out_valid_reg;
    assign granted_index = out_grant_reg;
    assign status        = out_status_reg;
    assign pready        = 1'b1;
    assign prdata        = (paddr[2] == REG_MIN_GROW) ? {16'h0, min_grow_reg} : 32'h0;

`ifndef SYNTHESIS
    a_top_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        {1'b0, heap_top_reg} <= (TOP_W + 1)'(HEAP_UNITS))
        else $error("heap top beyond heap");

    a_list_stays: assert property (@(posedge clk) disable iff (!rst_n)
        $past(started_reg) |-> started_reg)
        else $error("free list lost its start");

    a_zero_quick: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall && (func == FUNC_ALLOC) && (request_bytes == '0))
        |=> (state_reg == S_RESP) && (res_status_reg == ST_ZERO))
        else $error("zero request not answered at once");

    a_grant_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && (status == ST_GRANTED)) |-> (granted_index != '0))
        else $error("grant of payload zero");
`endif

endmodule
